>>> src/periodic_callback_timer_slots_defines.svh
// Assertion macros for the periodic timer slot table.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef PERIODIC_CALLBACK_TIMER_SLOTS_DEFINES_SVH
`define PERIODIC_CALLBACK_TIMER_SLOTS_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PCTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PCTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pcts_pkg.sv
// Shared types and constants for the periodic timer slot table.
// Used by pcts_slot, pcts_alloc and periodic_callback_timer_slots.
`timescale 1ns / 1ps
`default_nettype none

package pcts_pkg;

    localparam int REQ_W      = 2;
    localparam int PERIOD_W   = 16;
    localparam int IDX_W      = 3;
    localparam int MASK_W     = 8;
    localparam int FIELD_SLOTS = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK     = 2'd0,
        REQ_REGISTER = 2'd1,
        REQ_REMOVE   = 2'd2,
        REQ_NONE     = 2'd3
    } pcts_req_t;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [PERIOD_W-1:0] period_ms;
        logic [IDX_W-1:0]    slot_index;
    } pcts_req_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]  granted_slot;
        logic              table_full;
        logic [MASK_W-1:0] fired_mask;
    } pcts_rsp_word_t;

    typedef struct packed {
        logic tick;
        logic claim;
        logic remove;
    } pcts_slot_ctrl_t;

endpackage

`default_nettype wire

>>> src/pcts_slot.sv
// One timer slot: busy flag, period and saturating tick counter.
// Depends on pcts_pkg for the slot control struct.
`timescale 1ns / 1ps
`default_nettype none

module pcts_slot #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pcts_pkg::pcts_slot_ctrl_t   ctrl,
    input  wire logic [COUNT_BITS-1:0]       period,
    output logic                             busy,
    output logic                             fire
);
    import pcts_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic [COUNT_BITS-1:0] period_reg;
    logic [COUNT_BITS-1:0] period_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_inc;

    always_comb
    begin
        count_inc = (count_reg == '1) ? count_reg : count_reg + COUNT_BITS'(1);
        fire      = ctrl.tick && busy_reg && (count_inc >= period_reg);

        busy_next   = busy_reg;
        period_next = period_reg;
        count_next  = count_reg;
        if (ctrl.tick)
        begin
            count_next = fire ? '0 : count_inc;
        end
        if (ctrl.claim)
        begin
            busy_next   = 1'b1;
            period_next = period;
            count_next  = '0;
        end
        if (ctrl.remove)
        begin
            busy_next   = 1'b0;
            period_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            period_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            period_reg <= period_next;
            count_reg  <= count_next;
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

>>> src/pcts_alloc.sv
// Lowest-free-slot search over the claimable slots, slot 0 excluded.
// Depends on pcts_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module pcts_alloc #(
    parameter int USABLE_SLOTS = 8
) (
    input  wire logic [pcts_pkg::FIELD_SLOTS-1:0] busy,
    output logic [pcts_pkg::IDX_W-1:0]            grant,
    output logic                                  found
);
    import pcts_pkg::*;

    always_comb
    begin
        grant = '0;
        found = 1'b0;
        for (int i = 1; i < FIELD_SLOTS; i++)
        begin
            if ((i < USABLE_SLOTS) && !busy[i] && !found)
            begin
                grant = IDX_W'(i);
                found = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/periodic_callback_timer_slots.sv
// Top level of the periodic timer slot table: input register, slot cells,
// free-slot search and result register. Depends on pcts_pkg, pcts_slot,
// pcts_alloc and periodic_callback_timer_slots_defines.svh.
//
//   Channel | Valid     | Stall     | Word
//   --------+-----------+-----------+------------------------------
//   request | req_valid | req_stall | req (type, period, slot index)
//   result  | rsp_valid | rsp_stall | rsp (grant, full, fired mask)
//
// One request is taken every cycle while req_stall is low; its result is written from
// the input register into the result register and leaves it while rsp_stall is low.
// All slot cells update in parallel in the cycle a request leaves the input register.
// Reset clears every slot at once, so requests are taken right after reset.
// A stalled result holds the input register, and req_stall rises only then.
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_callback_timer_slots_defines.svh"

module periodic_callback_timer_slots #(
    parameter int NUM_SLOTS  = 8,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    output logic                          req_stall,
    input  wire pcts_pkg::pcts_req_word_t req,
    output logic                          rsp_valid,
    input  wire logic                     rsp_stall,
    output pcts_pkg::pcts_rsp_word_t      rsp
);
    import pcts_pkg::*;

    localparam int USABLE = (NUM_SLOTS < FIELD_SLOTS) ? NUM_SLOTS : FIELD_SLOTS;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    pcts_req_word_t        s1_word_reg;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    pcts_rsp_word_t        rsp_word_reg;
    pcts_rsp_word_t        rsp_word_next;

    logic                  advance;
    logic                  is_tick;
    logic                  is_register;
    logic                  is_remove;
    logic                  remove_ok;
    logic [COUNT_BITS-1:0] period_sat;
    logic [NUM_SLOTS-1:0]  busy_vec;
    logic [NUM_SLOTS-1:0]  fire_vec;
    logic [FIELD_SLOTS-1:0] busy8;
    logic [MASK_W-1:0]     fired8;
    logic [IDX_W-1:0]      grant;
    logic                  found;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !advance;

    always_comb
    begin
        is_tick     = 1'b0;
        is_register = 1'b0;
        is_remove   = 1'b0;
        unique case (s1_word_reg.req_type)
            REQ_TICK:     is_tick = 1'b1;
            REQ_REGISTER: is_register = 1'b1;
            REQ_REMOVE:   is_remove = 1'b1;
            default:      ;
        endcase
    end

    assign remove_ok = ({1'b0, s1_word_reg.slot_index} < (IDX_W + 1)'(USABLE));

    generate
        if (COUNT_BITS >= PERIOD_W)
        begin : g_period_wide
            assign period_sat = COUNT_BITS'(s1_word_reg.period_ms);
        end
        else
        begin : g_period_narrow
            assign period_sat = (|s1_word_reg.period_ms[PERIOD_W-1:COUNT_BITS]) ?
                                '1 : s1_word_reg.period_ms[COUNT_BITS-1:0];
        end
    endgenerate

    generate
        for (genvar i = 0; i < NUM_SLOTS; i++)
        begin : g_slot
            localparam bit Claimable = (i < USABLE);
            pcts_slot_ctrl_t ctrl;

            assign ctrl.tick   = advance && is_tick;
            assign ctrl.claim  = Claimable && advance && is_register && found &&
                                 (int'(grant) == i);
            assign ctrl.remove = Claimable && advance && is_remove && remove_ok &&
                                 (int'(s1_word_reg.slot_index) == i);

            pcts_slot #(
                .COUNT_BITS(COUNT_BITS)
            ) u_slot (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (ctrl),
                .period (period_sat),
                .busy   (busy_vec[i]),
                .fire   (fire_vec[i])
            );
        end
    endgenerate

    generate
        for (genvar j = 0; j < FIELD_SLOTS; j++)
        begin : g_field
            if (j < NUM_SLOTS)
            begin : g_present
                assign busy8[j]  = busy_vec[j];
                assign fired8[j] = fire_vec[j];
            end
            else
            begin : g_absent
                assign busy8[j]  = 1'b0;
                assign fired8[j] = 1'b0;
            end
        end
    endgenerate

    pcts_alloc #(
        .USABLE_SLOTS(USABLE)
    ) u_alloc (
        .busy  (busy8),
        .grant (grant),
        .found (found)
    );

    always_comb
    begin
        rsp_word_next.granted_slot = (is_register && found) ? grant : '0;
        rsp_word_next.table_full   = is_register && !found;
        rsp_word_next.fired_mask   = is_tick ? fired8 : '0;

        s1_valid_next = req_stall ? s1_valid_reg : req_valid;

        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            s1_word_reg <= req;
        end
        if (advance)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_word_reg;

    `PCTS_ASSERT_NOW(a_slot0_free, 1'b1, !busy8[0], "Reserved slot 0 became busy.")
    `PCTS_ASSERT_NEXT(a_claim_busy, advance && is_register && found,
        busy8[$past(grant)], "Claimed slot is not busy after a register request.")
    `PCTS_ASSERT_NEXT(a_hold_s1, req_stall,
        s1_valid_reg && $stable(s1_word_reg), "Input register changed while held.")

endmodule

`default_nettype wire
